// ===== rtl/ediu_pkg.sv =====
`timescale 1ns / 1ps
package ediu_pkg;

	localparam int MAX_SCALE_DEF = 6;
	localparam int DIST_W        = 14;
	localparam int SQ_W          = 28;
	localparam int SQ_STAGES     = 7;
	localparam int DIST_LAT      = SQ_STAGES + 2;
	localparam int N_LANES       = 18;
	localparam int Q_DEPTH       = 4;
	localparam int CFG_DW        = 14;
	localparam int CFG_IW        = 8;

	localparam logic [2:0]  SCALE_RST = 3'd2;
	localparam logic [13:0] TOL_RST   = 14'd480;
	localparam logic [11:0] DOM_RST   = 12'd922;
	localparam logic [11:0] STEEP_RST = 12'd563;

	localparam logic [CFG_IW-1:0] REG_SCALE = 8'd0;
	localparam logic [CFG_IW-1:0] REG_TOL   = 8'd1;
	localparam logic [CFG_IW-1:0] REG_DOM   = 8'd2;
	localparam logic [CFG_IW-1:0] REG_STEEP = 8'd3;

	typedef struct packed {
		logic [31:0] pix_up_left;
		logic [31:0] pix_up;
		logic [31:0] pix_up_right;
		logic [31:0] pix_left;
		logic [31:0] pix_center;
		logic [31:0] pix_right;
		logic [31:0] pix_down_left;
		logic [31:0] pix_down;
		logic [31:0] pix_down_right;
	} in_t;

	typedef struct packed {
		logic [31:0] out_color;
		logic [2:0]  out_row;
		logic [2:0]  out_col;
		logic        block_last;
	} out_t;

	typedef struct packed {
		logic [2:0]  n;
		logic [13:0] tol;
		logic [11:0] dom;
		logic [11:0] steep;
	} cfg_t;

	typedef struct packed {
		logic c0;
		logic vs;
		logic hs;
	} flags_t;

	typedef struct packed {
		logic [31:0] h;
		logic [31:0] d;
		logic [31:0] f;
		logic [31:0] j;
		logic [31:0] l;
	} col5_t;

	typedef struct packed {
		col5_t      col;
		flags_t [3:0] fl;
	} qent_t;

	typedef enum logic [1:0] {
		BL_NONE,
		BL_31,
		BL_53,
		BL_71
	} blend_t;

	typedef struct packed {
		logic [SQ_W-1:0] v;
		logic [SQ_W-1:0] r;
	} sq_t;

	function automatic sq_t sq_step(sq_t x, logic [SQ_W-1:0] b);
		sq_t y;
		y = x;
		if (x.v >= x.r + b) begin
			y.v = x.v - (x.r + b);
			y.r = (x.r >> 1) + b;
		end else begin
			y.r = x.r >> 1;
		end
		return y;
	endfunction

endpackage

// ===== rtl/edge_directed_pixel_upscaler_core.sv =====
`timescale 1ns / 1ps
// Throughput: the single pixel output port sends N*N pixel beats per neighborhood
// (4 at 2x, 36 at 6x); the 12-stage distance front takes one beat a cycle while
// the queue is not full, so it takes new neighborhoods before earlier ones finish.
// Reset: arst_n clears the pipeline, queue and pixel counters and loads the
// configuration registers with their defaults.
module edge_directed_pixel_upscaler_core #(
	parameter int MAX_SCALE = ediu_pkg::MAX_SCALE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ediu_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ediu_pkg::out_t                out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ediu_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [ediu_pkg::CFG_DW-1:0]   cfg_data
);
	import ediu_pkg::*;

	logic [2:0]  scale_q;
	logic [13:0] tol_q;
	logic [11:0] dom_q, steep_q;
	cfg_t        cfg;
	logic        push, pop, q_full, q_empty;
	qent_t       push_data, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			tol_q   <= TOL_RST;
			dom_q   <= DOM_RST;
			steep_q <= STEEP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCALE: scale_q <= cfg_data[2:0];
				REG_TOL:   tol_q   <= cfg_data[13:0];
				REG_DOM:   dom_q   <= cfg_data[11:0];
				REG_STEEP: steep_q <= cfg_data[11:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		cfg.tol   = tol_q;
		cfg.dom   = dom_q;
		cfg.steep = steep_q;
		if (scale_q < 3'd2)
			cfg.n = 3'd2;
		else if (scale_q > 3'(MAX_SCALE))
			cfg.n = 3'(MAX_SCALE);
		else
			cfg.n = scale_q;
	end

	ediu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	ediu_fifo #(
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.pop    (pop),
		.dout   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	ediu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.n          (cfg.n),
		.head       (head),
		.head_valid (!q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== rtl/ediu_dist.sv =====
`timescale 1ns / 1ps
module ediu_dist (
	input  logic                         clk,
	input  logic                         en,
	input  logic [31:0]                  a,
	input  logic [31:0]                  b,
	output logic [ediu_pkg::DIST_W-1:0]  distance
);
	import ediu_pkg::*;

	logic [7:0]  dr, dg, db;
	logic [8:0]  rsum;
	logic [15:0] sqr_s1, sqg_s1, sqb_s1;
	logic        hi_s1;
	logic [19:0] r20, g20, b20, s_c;
	logic [SQ_W-1:0] v_s2;
	sq_t rt_s [SQ_STAGES];

	always_comb begin
		dr   = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
		dg   = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
		db   = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
		rsum = {1'b0, a[23:16]} + {1'b0, b[23:16]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqr_s1 <= dr * dr;
			sqg_s1 <= dg * dg;
			sqb_s1 <= db * db;
			hi_s1  <= rsum[8];
		end
	end

	always_comb begin
		r20 = 20'(sqr_s1);
		g20 = 20'(sqg_s1);
		b20 = 20'(sqb_s1);
		if (hi_s1)
			s_c = r20 + (r20 << 1) + (g20 << 2) + (b20 << 1);
		else
			s_c = (r20 << 1) + (g20 << 2) + b20 + (b20 << 1);
	end

	always_ff @(posedge clk) begin
		if (en)
			v_s2 <= {s_c, 8'b0};
	end

	// two root digits per stage
	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_rt
		localparam logic [SQ_W-1:0] B0 = SQ_W'(1) << (SQ_W - 2 - 4 * j);
		localparam logic [SQ_W-1:0] B1 = SQ_W'(1) << (SQ_W - 4 - 4 * j);
		sq_t src;
		if (j == 0) begin : g_first
			assign src = '{v: v_s2, r: '0};
		end else begin : g_next
			assign src = rt_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en)
				rt_s[j] <= sq_step(sq_step(src, B0), B1);
		end
	end

	assign distance = rt_s[SQ_STAGES-1].r[DIST_W-1:0];

endmodule

// ===== rtl/ediu_front.sv =====
`timescale 1ns / 1ps
module ediu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  ediu_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  ediu_pkg::in_t    in_data,
	output logic             push,
	output ediu_pkg::qent_t  push_data,
	input  logic             q_full
);
	import ediu_pkg::*;

	localparam int FL = DIST_LAT + 2;
	// lane pick per corner TL, TR, BL, BR
	localparam int LX[4] = '{0, 1, 2, 3};
	localparam int LP[4] = '{4, 5, 6, 7};
	localparam int LO[4] = '{8, 9, 10, 11};
	localparam int LQ[4] = '{12, 13, 12, 8};
	localparam int LV[4] = '{14, 16, 14, 16};
	localparam int LH[4] = '{15, 15, 17, 17};

	logic            en;
	logic [FL:0]     vld_q;
	col5_t           car_q [FL+1];
	in_t             p_s0;
	logic [31:0]     la [N_LANES];
	logic [31:0]     lb [N_LANES];
	logic [DIST_W-1:0] lane_dist [N_LANES];
	flags_t [3:0]    fl_s11;

	assign en       = !vld_q[FL] || !q_full;
	assign in_ready = en;
	assign push     = vld_q[FL] && !q_full;
	assign push_data = '{col: car_q[FL], fl: fl_s11};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[FL-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s0     <= in_data;
			car_q[0] <= '{h: in_data.pix_center, d: in_data.pix_up_left,
				f: in_data.pix_up_right, j: in_data.pix_down_left,
				l: in_data.pix_down_right};
			for (int i = 1; i <= FL; i++)
				car_q[i] <= car_q[i-1];
		end
	end

	always_comb begin
		la[0]  = p_s0.pix_center;   lb[0]  = p_s0.pix_up_left;
		la[1]  = p_s0.pix_center;   lb[1]  = p_s0.pix_up_right;
		la[2]  = p_s0.pix_center;   lb[2]  = p_s0.pix_down_left;
		la[3]  = p_s0.pix_center;   lb[3]  = p_s0.pix_down_right;
		la[4]  = p_s0.pix_up_left;  lb[4]  = p_s0.pix_up;
		la[5]  = p_s0.pix_up_left;  lb[5]  = p_s0.pix_right;
		la[6]  = p_s0.pix_up;       lb[6]  = p_s0.pix_down;
		la[7]  = p_s0.pix_up_right; lb[7]  = p_s0.pix_down;
		la[8]  = p_s0.pix_left;     lb[8]  = p_s0.pix_up;
		la[9]  = p_s0.pix_up;       lb[9]  = p_s0.pix_right;
		la[10] = p_s0.pix_left;     lb[10] = p_s0.pix_down;
		la[11] = p_s0.pix_right;    lb[11] = p_s0.pix_down;
		la[12] = p_s0.pix_up_right; lb[12] = p_s0.pix_right;
		la[13] = p_s0.pix_down_right; lb[13] = p_s0.pix_left;
		la[14] = p_s0.pix_center;   lb[14] = p_s0.pix_left;
		la[15] = p_s0.pix_center;   lb[15] = p_s0.pix_up;
		la[16] = p_s0.pix_center;   lb[16] = p_s0.pix_right;
		la[17] = p_s0.pix_center;   lb[17] = p_s0.pix_down;
	end

	for (genvar i = 0; i < N_LANES; i++) begin : g_lane
		ediu_dist u_dist (
			.clk      (clk),
			.en       (en),
			.a        (la[i]),
			.b        (lb[i]),
			.distance (lane_dist[i])
		);
	end

	for (genvar k = 0; k < 4; k++) begin : g_corner
		logic [DIST_W:0]   td_c, to_c;
		logic              ge_s10, gt_s10, lt_s10;
		logic [DIST_W:0]   td_s10;
		logic [26:0]       tom_s10;
		logic [25:0]       dst_s10;
		logic [DIST_W-1:0] dv_s10, dh_s10;
		logic              none_c, dom_c, st_c, sh_c;

		assign td_c = {1'b0, lane_dist[LX[k]]} + {1'b0, lane_dist[LP[k]]};
		assign to_c = {1'b0, lane_dist[LO[k]]} + {1'b0, lane_dist[LQ[k]]};

		always_ff @(posedge clk) begin
			if (en) begin
				ge_s10  <= lane_dist[LX[k]] >= cfg.tol;
				gt_s10  <= lane_dist[LX[k]] > cfg.tol;
				lt_s10  <= td_c < to_c;
				td_s10  <= td_c;
				tom_s10 <= 27'(to_c) * 27'(cfg.dom);
				dst_s10 <= 26'(lane_dist[LX[k]]) * 26'(cfg.steep);
				dv_s10  <= lane_dist[LV[k]];
				dh_s10  <= lane_dist[LH[k]];
			end
		end

		always_comb begin
			none_c = !ge_s10 || lt_s10;
			dom_c  = {4'b0, td_s10, 8'b0} > tom_s10;
			st_c   = {4'b0, dv_s10, 8'b0} < dst_s10;
			sh_c   = {4'b0, dh_s10, 8'b0} < dst_s10;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cfg.n == 3'd2) begin
					fl_s11[k].c0 <= !none_c && gt_s10 && (st_c || sh_c);
					fl_s11[k].vs <= 1'b0;
					fl_s11[k].hs <= 1'b0;
				end else if (cfg.n == 3'd3) begin
					fl_s11[k].c0 <= !none_c;
					fl_s11[k].vs <= !none_c && st_c && dom_c;
					fl_s11[k].hs <= !none_c && sh_c && dom_c;
				end else begin
					fl_s11[k].c0 <= !none_c;
					fl_s11[k].vs <= !none_c && (st_c || dom_c);
					fl_s11[k].hs <= !none_c && (sh_c || dom_c);
				end
			end
		end
	end

endmodule

// ===== rtl/ediu_fifo.sv =====
`timescale 1ns / 1ps
module ediu_fifo #(
	parameter int DEPTH = ediu_pkg::Q_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ediu_pkg::qent_t  din,
	input  logic             pop,
	output ediu_pkg::qent_t  dout,
	output logic             full,
	output logic             empty
);
	import ediu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qent_t         mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance");

endmodule

// ===== rtl/ediu_back.sv =====
`timescale 1ns / 1ps
module ediu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       n,
	input  ediu_pkg::qent_t  head,
	input  logic             head_valid,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output ediu_pkg::out_t   out_data
);
	import ediu_pkg::*;

	logic [2:0]  e;
	logic [2:0]  r_q, c_q;
	logic        fire, last;
	blend_t      sel;
	logic [31:0] x_c, color_c;
	logic [3:0]  w_c;
	logic        out_vld_q;
	out_t        out_q;

	assign e         = n - 3'd1;
	assign last      = (r_q == e) && (c_q == e);
	assign fire      = head_valid && (!out_vld_q || out_ready);
	assign pop       = fire && last;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// later corners override earlier ones
	always_comb begin
		logic        top, left;
		logic [2:0]  rc, r1, r2, cc, c1, c2;
		logic [31:0] xk;
		sel = BL_NONE;
		x_c = head.col.d;
		for (int k = 0; k < 4; k++) begin
			top  = (k < 2);
			left = (k == 0) || (k == 2);
			rc   = top ? 3'd0 : e;
			r1   = top ? 3'd1 : e - 3'd1;
			r2   = top ? 3'd2 : e - 3'd2;
			cc   = left ? 3'd0 : e;
			c1   = left ? 3'd1 : e - 3'd1;
			c2   = left ? 3'd2 : e - 3'd2;
			case (k)
				0:       xk = head.col.d;
				1:       xk = head.col.f;
				2:       xk = head.col.j;
				default: xk = head.col.l;
			endcase
			if (head.fl[k].c0 && r_q == rc && c_q == cc) begin
				sel = BL_31;
				x_c = xk;
			end
			if (head.fl[k].vs && c_q == cc) begin
				if (r_q == r1) begin
					sel = (n == 3'd3) ? BL_71 : BL_53;
					x_c = xk;
				end else if (n != 3'd3 && r_q == r2) begin
					sel = BL_71;
					x_c = xk;
				end
			end
			if (head.fl[k].hs && r_q == rc) begin
				if (c_q == c1) begin
					sel = (n == 3'd3) ? BL_71 : BL_53;
					x_c = xk;
				end else if (n != 3'd3 && c_q == c2) begin
					sel = BL_71;
					x_c = xk;
				end
			end
		end
	end

	always_comb begin
		logic [10:0] acc;
		case (sel)
			BL_31:   w_c = 4'd6;
			BL_53:   w_c = 4'd5;
			BL_71:   w_c = 4'd7;
			default: w_c = 4'd8;
		endcase
		color_c = {8'hFF, 24'b0};
		for (int s = 0; s < 3; s++) begin
			acc = 11'(head.col.h[s*8 +: 8]) * 11'(w_c)
				+ 11'(x_c[s*8 +: 8]) * 11'(4'd8 - w_c);
			color_c[s*8 +: 8] = acc[10:3];
		end
		if (sel == BL_NONE)
			color_c = head.col.h;
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_q <= '{out_color: color_c, out_row: r_q, out_col: c_q, block_last: last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			r_q       <= '0;
			c_q       <= '0;
		end else begin
			if (fire) begin
				out_vld_q <= 1'b1;
				if (c_q == e) begin
					c_q <= '0;
					r_q <= (r_q == e) ? 3'd0 : r_q + 3'd1;
				end else begin
					c_q <= c_q + 3'd1;
				end
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_pop_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (r_q == 3'd0 && c_q == 3'd0))
		else $error("block pointer not rewound after last beat");
	a_pos_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (r_q <= e && c_q <= e))
		else $error("pixel position outside block");

endmodule
